FILE: rtl/core/pis_pkg.sv
// Package for the particle integrator: shared types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pis_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DW            = 32;
  localparam int CW            = 31;

  typedef enum logic [2:0] {
    MODE_EULER = 3'd0,
    MODE_VERLET = 3'd1,
    MODE_RK1 = 3'd2,
    MODE_RK2 = 3'd3,
    MODE_RK3 = 3'd4,
    MODE_RK4 = 3'd5,
    MODE_SPEED = 3'd6,
    MODE_LOAD = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_INV_TIME_STEP = 2'd1,
    CFG_INV_MASS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALAR,
    ST_AXIS,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;      // capture input item
    logic       scalar;    // form scalar factors (one step)
    logic       axis;      // run one axis step
    logic [1:0] axis_idx;
    logic       finish;    // close item, update flag
  } pis_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       scalar_done;
    logic       axis_done;
  } pis_sts_t;

  // Saturate a 66-bit signed value to 32 bits
  function automatic logic signed [DW-1:0] sat66(input logic signed [65:0] v);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    mx = 66'sd2147483647;
    mn = -66'sd2147483648;
    if (v > mx) sat66 = 32'sh7fffffff;
    else if (v < mn) sat66 = 32'sh80000000;
    else sat66 = v[DW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/particle_integrator_step.sv
// Channel   Dir  tdata                                   tuser
// in_       in   force_x/y/z, impulse_x/y/z (192b)       mode (3b)
// out_      out  pos_x/y/z, vel_x/y/z (192b)             -
// cfg_      in   write enable, index, 31-bit data        -
// One item runs the scalar steps, then per axis 1 to 6 multiply steps on one
// shared 32x32 multiplier, plus accept, finish and capture.
// Reset (rst_n, synchronous) clears control, position, velocity and flag state and loads register defaults.
// The output register holds a result until taken; a new item is accepted
// while it waits, and the next result waits in the controller.
// Top level; depends on pis_pkg, pis_ctrl, pis_dp.
`timescale 1ns / 1ps
`default_nettype none
module particle_integrator_step
  import pis_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [191:0]   in_tdata,  // force_x, force_y, force_z, impulse_x/y/z
  input  wire logic [2:0]     in_tuser,  // mode
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [191:0]        out_tdata, // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_idx,
  input  wire logic [CW-1:0]  cfg_wdata
);

  pis_cmd_t cmd;
  pis_sts_t sts;
  logic push, out_busy;
  logic signed [DW-1:0] f [3], imp [3], pos [3], vel [3];
  logic [191:0] out_tdata_r;
  logic out_tvalid_r;

  // Unpack the input transfer
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f[i]   = in_tdata[i*DW +: DW];
      imp[i] = in_tdata[(3+i)*DW +: DW];
    end
  end

  assign out_busy = out_tvalid_r && !out_tready;

  pis_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_busy, .sts, .cmd,
    .out_push(push)
  );

  pis_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata, .mode_i(in_tuser),
    .f_i(f), .imp_i(imp), .cmd, .sts, .pos_o(pos), .vel_o(vel)
  );

  // Output register: capture final state in the cycle after finish
  logic push_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      push_r       <= 1'b0;
    end else begin
      push_r <= push;
      if (push_r) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
    if (push_r)
      out_tdata_r <= {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !(out_tvalid && !out_tready)) else $error("overwrite");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("back to back");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/pis_ctrl.sv
// Controller state machine for the particle integrator.
// Depends on pis_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pis_ctrl
  import pis_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic     out_busy,
  input  wire pis_sts_t sts,
  output pis_cmd_t      cmd,
  output logic          out_push
);

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.axis_idx = axis_r;
    in_tready = 1'b0;
    out_push  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCALAR;
          axis_nxt  = 2'd0;
        end
      end
      ST_SCALAR: begin
        cmd.scalar = 1'b1;
        if (sts.scalar_done) state_nxt = ST_AXIS;
      end
      ST_AXIS: begin
        cmd.axis = 1'b1;
        if (sts.axis_done) begin
          if (axis_r == 2'd2) state_nxt = ST_DONE;
          else axis_nxt = axis_r + 2'd1;
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          out_push   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_push_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_busy) else $error("push into full output");
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    axis_r != 2'd3) else $error("axis index out of range");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/pis_dp.sv
// Datapath for the particle integrator: config, state, one shared multiplier.
// Depends on pis_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pis_dp
  import pis_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_idx,
  input  wire logic [CW-1:0]        cfg_wdata,
  input  wire logic [2:0]           mode_i,
  input  wire logic signed [DW-1:0] f_i [3],
  input  wire logic signed [DW-1:0] imp_i [3],
  input  wire pis_cmd_t             cmd,
  output pis_sts_t                  sts,
  output logic signed [DW-1:0]      pos_o [3],
  output logic signed [DW-1:0]      vel_o [3]
);

  localparam logic signed [DW-1:0] W6  = DW'(((64'sd1 <<< FRAC_BITS) + 3) / 6);
  localparam logic signed [DW-1:0] W3  = DW'(((64'sd1 <<< FRAC_BITS) + 1) / 3);

  logic [CW-1:0] dt_r, idt_r, im_r;
  logic signed [DW-1:0] p_r [3], pp_r [3], v_r [3], sp_r [3], sv_r [3];
  logic signed [DW-1:0] rp_r [3], rv_r [3];
  logic signed [DW-1:0] f_r [3], imp_r [3];
  logic          sg_r;
  mode_t         mode_r;
  logic signed [DW-1:0] sfm_r, svl_r, smt_r, dt2_r;
  logic [3:0]    step_r;
  logic signed [DW-1:0] t0_r, t1_r; // per axis temporaries

  // Shared multiplier: floor shift then saturate
  logic signed [DW-1:0] ma, mb, mres;
  logic signed [2*DW-1:0] mprod;
  always_comb begin
    mprod = ma * mb;
    mres  = sat66(66'(mprod >>> FRAC_BITS));
  end

  function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    sadd = sat66(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    ssub = sat66(66'(a) - 66'(b));
  endfunction

  logic [1:0] ax;
  logic signed [DW-1:0] w, dts, idts, ims;
  logic last;
  assign ax   = cmd.axis_idx;
  assign dts  = {1'b0, dt_r};
  assign idts = {1'b0, idt_r};
  assign ims  = {1'b0, im_r};
  assign w    = (mode_r == MODE_RK1 || mode_r == MODE_RK4) ? W6 : W3;

  // Multiplier operand select per step
  always_comb begin
    ma = '0; mb = '0; last = 1'b0;
    if (cmd.scalar) begin
      case (step_r)
        4'd0: begin ma = dts; mb = ims; end
        4'd1: begin ma = ims; mb = dts; end
        4'd2: begin ma = dts; mb = dts; end
        default: begin ma = dt2_r; mb = ims; end
      endcase
    end else begin
      case (mode_r)
        MODE_EULER: case (step_r)
          4'd0: begin ma = imp_r[ax]; mb = ims; end
          4'd1: begin ma = t0_r; mb = dts; end
          default: begin ma = f_r[ax]; mb = sfm_r; last = 1'b1; end
        endcase
        MODE_VERLET: case (step_r)
          4'd0: begin ma = v_r[ax]; mb = dts; end
          4'd1: begin ma = f_r[ax]; mb = svl_r; end
          default: begin ma = t1_r; mb = idts; last = 1'b1; end
        endcase
        MODE_SPEED: begin ma = ssub(p_r[ax], pp_r[ax]); mb = idts; last = 1'b1; end
        MODE_LOAD: last = 1'b1;
        default: case (step_r)
          4'd0: begin ma = v_r[ax]; mb = dts; end
          4'd1: begin ma = t0_r; mb = w; end
          4'd2: begin ma = f_r[ax]; mb = sfm_r; end
          4'd3: begin ma = t1_r; mb = w; last = (mode_r != MODE_RK4); end
          4'd4: begin ma = imp_r[ax]; mb = ims; end
          default: begin ma = imp_r[ax]; mb = smt_r; last = 1'b1; end
        endcase
      endcase
    end
  end

  assign sts.scalar_done = cmd.scalar && step_r == 4'd3;
  assign sts.axis_done   = cmd.axis && last;

  logic signed [DW-1:0] spx, svx;
  assign spx = (mode_r == MODE_RK1) ? p_r[ax] : sp_r[ax];
  assign svx = (mode_r == MODE_RK1) ? v_r[ax] : sv_r[ax];

  // Verlet new position, formed exactly and saturated once
  logic signed [DW-1:0] vn;
  assign vn = sat66((66'(p_r[ax]) <<< 1) - 66'(t0_r) + 66'(mres));

  // Sequenced state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= CW'(655); idt_r <= CW'(6553600); im_r <= CW'(65536);
      sg_r <= 1'b0; step_r <= '0; mode_r <= MODE_EULER;
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= '0; pp_r[i] <= '0; v_r[i] <= '0; sp_r[i] <= '0;
        sv_r[i] <= '0; rp_r[i] <= '0; rv_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TIME_STEP:     dt_r  <= cfg_wdata;
          CFG_INV_TIME_STEP: idt_r <= cfg_wdata;
          CFG_INV_MASS:      im_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        mode_r <= mode_t'(mode_i);
        f_r <= f_i; imp_r <= imp_i; step_r <= '0;
      end
      if (cmd.scalar) begin
        step_r <= sts.scalar_done ? 4'd0 : step_r + 4'd1;
        case (step_r)
          4'd0: sfm_r <= mres;
          4'd1: smt_r <= mres;
          4'd2: dt2_r <= mres;
          default: svl_r <= mres;
        endcase
      end
      if (cmd.axis) begin
        step_r <= last ? 4'd0 : step_r + 4'd1;
        case (mode_r)
          MODE_EULER: case (step_r)
            4'd0: begin pp_r[ax] <= p_r[ax]; t0_r <= sadd(v_r[ax], mres);
                        v_r[ax] <= sadd(v_r[ax], mres); end
            4'd1: p_r[ax] <= sadd(p_r[ax], mres);
            default: v_r[ax] <= sadd(v_r[ax], mres);
          endcase
          MODE_VERLET: case (step_r)
            4'd0: t0_r <= sg_r ? ssub(p_r[ax], mres) : pp_r[ax];
            4'd1: begin
              pp_r[ax] <= p_r[ax];
              p_r[ax]  <= vn;
              t1_r     <= ssub(vn, p_r[ax]);
            end
            default: v_r[ax] <= mres;
          endcase
          MODE_SPEED: v_r[ax] <= mres;
          MODE_LOAD: begin p_r[ax] <= f_r[ax]; v_r[ax] <= imp_r[ax]; end
          default: case (step_r)
            4'd0: begin
              t0_r <= mres;
              if (mode_r == MODE_RK1) begin sp_r[ax] <= p_r[ax]; sv_r[ax] <= v_r[ax]; end
              if (mode_r == MODE_RK4) pp_r[ax] <= spx;
              else if (mode_r == MODE_RK3) p_r[ax] <= sadd(spx, mres);
              else p_r[ax] <= sadd(spx, mres >>> 1);
            end
            4'd1: begin
              rp_r[ax] <= (mode_r == MODE_RK1) ? mres : sadd(rp_r[ax], mres);
              if (mode_r == MODE_RK4) p_r[ax] <= sadd(sp_r[ax], sadd(rp_r[ax], mres));
            end
            4'd2: begin
              t1_r <= mres;
              if (mode_r == MODE_RK3) v_r[ax] <= sadd(svx, mres);
              else if (mode_r != MODE_RK4) v_r[ax] <= sadd(svx, mres >>> 1);
            end
            4'd3: begin
              rv_r[ax] <= (mode_r == MODE_RK1) ? mres : sadd(rv_r[ax], mres);
              if (mode_r == MODE_RK4) v_r[ax] <= sadd(sv_r[ax], sadd(rv_r[ax], mres));
            end
            4'd4: v_r[ax] <= sadd(v_r[ax], mres);
            default: p_r[ax] <= sadd(p_r[ax], mres);
          endcase
        endcase
      end
      if (cmd.finish) begin
        if (mode_r == MODE_VERLET) sg_r <= 1'b0;
        else if (mode_r == MODE_LOAD) sg_r <= 1'b1;
      end
    end
  end

  assign pos_o = p_r;
  assign vel_o = v_r;

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.scalar && cmd.axis)) else $error("scalar and axis together");
  a_step_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> step_r == 4'd0) else $error("step not cleared");
  a_step_rng: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < 4'd6) else $error("step out of range");
`endif

endmodule
`default_nettype wire
